[rtl/sorted_priority_stack_defines.svh]
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_STACK_DEFINES_SVH
`define SORTED_PRIORITY_STACK_DEFINES_SVH

// Labeled concurrent assertion on the default clock and reset names.
`define SPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted_priority_stack assertion failed");

// Labeled assertion whose consequent is checked in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_priority_stack assertion failed");

`endif

[rtl/sps_pkg.sv]
`timescale 1ns / 1ps

package sps_pkg;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned CntW        = $clog2(Capacity + 1);
  localparam int unsigned ElemW       = 32;
  localparam int unsigned PrioW       = 32;
  localparam int unsigned CountFieldW = 5;
  localparam int unsigned InDataW     = 64;
  localparam int unsigned OutDataW    = 72;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  typedef struct packed {
    logic [ElemW-1:0] elem;
    logic [PrioW-1:0] prio;
  } cell_data_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    cell_data_t data;
  } cell_ctl_t;

endpackage

[rtl/sps_cell.sv]
`timescale 1ns / 1ps

module sps_cell (
  input  logic               clk_i,
  input  sps_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               left_ins_i,
  input  sps_pkg::cell_data_t left_i,
  input  sps_pkg::cell_data_t right_i,
  output logic               ins_o,
  output sps_pkg::cell_data_t data_o
);

  sps_pkg::cell_data_t data_q, data_d;

  // A free cell, or one whose priority is not above the new one, gives way.
  assign ins_o = !occ_i || (data_q.prio <= ctl_i.data.prio);

  always_comb begin
    data_d = data_q;
    if (ctl_i.push && ins_o) begin
      data_d = left_ins_i ? left_i : ctl_i.data;
    end else if (ctl_i.pop) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/sorted_priority_stack.sv]
`timescale 1ns / 1ps
// The result of an accepted transaction is shown in the next cycle.
// Throughput: one push or pop per cycle while the result side keeps taking results.
// Every cell compares and shifts in parallel to perform a sorted insert.
// Reset: asynchronous, active low; clears the entry count and the result valid flag.
// Cell contents are not reset; cells beyond the count are never shown.

module sorted_priority_stack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // elem_in [31:0], prio_in [63:32]
  input  logic [sps_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // top_elem [31:0], top_prio [63:32], count [68:64], is_empty [69],
  // is_full [70], op_error [71]
  output logic [sps_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned Cap  = sps_pkg::Capacity;
  localparam int unsigned CntW = sps_pkg::CntW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_vld_q;
  logic            err_q;

  logic accept, full, empty, push_ok, pop_ok;

  sps_pkg::cell_ctl_t  ctl;
  sps_pkg::cell_data_t cell_data [Cap];
  logic                cell_ins  [Cap];

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign full    = (cnt_q == CntW'(Cap));
  assign empty   = (cnt_q == '0);
  assign push_ok = accept && (s_axis_tuser_i == sps_pkg::CmdPush) && !full;
  assign pop_ok  = accept && (s_axis_tuser_i == sps_pkg::CmdPop) && !empty;

  assign ctl.push      = push_ok;
  assign ctl.pop       = pop_ok;
  assign ctl.data.elem = s_axis_tdata_i[sps_pkg::ElemW-1:0];
  assign ctl.data.prio = s_axis_tdata_i[sps_pkg::ElemW +: sps_pkg::PrioW];

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic                occ;
    logic                left_ins;
    sps_pkg::cell_data_t left_d;
    sps_pkg::cell_data_t right_d;

    assign occ = (cnt_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_ins = 1'b0;
      assign left_d   = ctl.data;
    end else begin : g_body
      assign left_ins = cell_ins[i-1];
      assign left_d   = cell_data[i-1];
    end

    if (i == Cap - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    sps_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .occ_i     (occ),
      .left_ins_i(left_ins),
      .left_i    (left_d),
      .right_i   (right_d),
      .ins_o     (cell_ins[i]),
      .data_o    (cell_data[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= !(push_ok || pop_ok);
    end
  end

  // Mask the top cell when the store is empty.
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {err_q, full, empty,
                            sps_pkg::CountFieldW'(cnt_q),
                            empty ? '0 : cell_data[0].prio,
                            empty ? '0 : cell_data[0].elem};

endmodule

[rtl/sps_checker.sv]
`timescale 1ns / 1ps
`include "sorted_priority_stack_defines.svh"

module sps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [sps_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic [4:0] cnt_f;
  logic       empty_f, full_f;

  assign cnt_f   = m_axis_tdata_o[68:64];
  assign empty_f = m_axis_tdata_o[69];
  assign full_f  = m_axis_tdata_o[70];

  `SPS_ASSERT(a_empty_flag, m_axis_tvalid_o |-> (empty_f == (cnt_f == 5'd0)))
  `SPS_ASSERT(a_full_flag, m_axis_tvalid_o |-> (full_f == (cnt_f == 5'd16)))
  `SPS_ASSERT(a_empty_zero, (m_axis_tvalid_o && empty_f) |-> (m_axis_tdata_o[63:0] == 64'd0))
  `SPS_ASSERT_NEXT(a_result_follows, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o)
  `SPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind sorted_priority_stack sps_checker u_sps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

[tb/sv/sorted_priority_stack_tb.sv]
`timescale 1ns / 1ps

module sorted_priority_stack_tb;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned StimItems = 1900;

  typedef struct {
    logic                      cmd;
    logic [sps_pkg::ElemW-1:0] elem;
    logic [sps_pkg::PrioW-1:0] prio;
  } stack_op_t;

  // Same layout as the result tdata, lowest field last.
  typedef struct packed {
    logic                            op_error;
    logic                            is_full;
    logic                            is_empty;
    logic [sps_pkg::CountFieldW-1:0] count;
    logic [sps_pkg::PrioW-1:0]       prio;
    logic [sps_pkg::ElemW-1:0]       elem;
  } top_view_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [sps_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [sps_pkg::OutDataW-1:0] m_axis_tdata;

  stack_op_t pending_ops[$];
  top_view_t expected_tops[$];

  // Predicted store contents, top entry first
  logic [sps_pkg::ElemW-1:0] sorted_elems [sps_pkg::Capacity];
  logic [sps_pkg::PrioW-1:0] sorted_prios [sps_pkg::Capacity];
  int unsigned               sorted_cnt   = 0;

  int unsigned gen_cnt     = 0;  // fill level as seen by the stimulus generator
  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned total_items = 0;
  int unsigned done_cnt    = 0;
  int          src_gap     = 0;
  int          snk_gap     = 0;
  int          src_quiet   = 0;
  int          snk_quiet   = 0;

  sorted_priority_stack u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one push or pop to the predicted store and return the top view after it.
  function automatic top_view_t sorted_apply(stack_op_t op);
    top_view_t   v;
    int unsigned pos;
    v.op_error = 1'b0;
    if (op.cmd == sps_pkg::CmdPush) begin
      if (sorted_cnt == sps_pkg::Capacity) begin
        v.op_error = 1'b1;
      end else begin
        // Go past strictly higher priorities only, so ties come out last-in first-out
        pos = 0;
        while (pos < sorted_cnt && sorted_prios[pos] > op.prio) pos++;
        for (int unsigned i = sorted_cnt; i > pos; i--) begin
          sorted_elems[i] = sorted_elems[i-1];
          sorted_prios[i] = sorted_prios[i-1];
        end
        sorted_elems[pos] = op.elem;
        sorted_prios[pos] = op.prio;
        sorted_cnt++;
      end
    end else begin
      if (sorted_cnt == 0) begin
        v.op_error = 1'b1;
      end else begin
        for (int unsigned i = 0; i + 1 < sorted_cnt; i++) begin
          sorted_elems[i] = sorted_elems[i+1];
          sorted_prios[i] = sorted_prios[i+1];
        end
        sorted_cnt--;
      end
    end
    v.elem     = (sorted_cnt != 0) ? sorted_elems[0] : '0;
    v.prio     = (sorted_cnt != 0) ? sorted_prios[0] : '0;
    v.count    = sps_pkg::CountFieldW'(sorted_cnt);
    v.is_empty = (sorted_cnt == 0);
    v.is_full  = (sorted_cnt == sps_pkg::Capacity);
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic queue_push(logic [sps_pkg::ElemW-1:0] e, logic [sps_pkg::PrioW-1:0] p);
    stack_op_t op;
    op.cmd  = sps_pkg::CmdPush;
    op.elem = e;
    op.prio = p;
    pending_ops.push_back(op);
    if (gen_cnt < sps_pkg::Capacity) gen_cnt++;
  endtask

  task automatic queue_pop();
    stack_op_t op;
    op.cmd  = sps_pkg::CmdPop;
    op.elem = $urandom;
    op.prio = $urandom;
    pending_ops.push_back(op);
    if (gen_cnt > 0) gen_cnt--;
  endtask

  // A narrow range of priorities makes ties common.
  function automatic logic [sps_pkg::PrioW-1:0] pick_prio(bit narrow);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (narrow) return sps_pkg::PrioW'($urandom_range(0, 3));
    case (r)
      0: return '0;
      1: return '1;
      2: return sps_pkg::PrioW'($urandom_range(0, 7));
      3: return ~sps_pkg::PrioW'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int gap_len(inout int quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 3) begin
      quiet = $urandom_range(20, 120);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: predict on each accepted transaction, then present the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    stack_op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      sorted_cnt = 0;
      src_gap    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        op.cmd  = s_axis_tuser;
        op.elem = s_axis_tdata[sps_pkg::ElemW-1:0];
        op.prio = s_axis_tdata[sps_pkg::ElemW+sps_pkg::PrioW-1:sps_pkg::ElemW];
        expected_tops.push_back(sorted_apply(op));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          s_axis_tuser  <= op.cmd;
          s_axis_tdata  <= {op.prio, op.elem};
          s_axis_tvalid <= 1'b1;
          src_gap = gap_len(src_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    top_view_t got;
    top_view_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = top_view_t'(m_axis_tdata);
        if (expected_tops.size() == 0) begin
          report_mismatch("unexpected result", got.elem, '0);
        end else begin
          want = expected_tops.pop_front();
          done_cnt++;
          if (got.elem !== want.elem) report_mismatch("top_elem", got.elem, want.elem);
          if (got.prio !== want.prio) report_mismatch("top_prio", got.prio, want.prio);
          if (got.count !== want.count) report_mismatch("count", got.count, want.count);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.is_full !== want.is_full)
            report_mismatch("is_full", got.is_full, want.is_full);
          if (got.op_error !== want.op_error)
            report_mismatch("op_error", got.op_error, want.op_error);
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        snk_gap = gap_len(snk_quiet);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL sorted_priority_stack");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned n;
    bit          narrow;

    // Pop on empty, extreme values, ties, fill to full, push on full
    queue_pop();
    queue_push('1, '1);
    queue_push('0, '0);
    queue_push(32'h1111_1111, 32'd7);
    queue_push(32'h2222_2222, 32'd7);
    queue_push(32'h3333_3333, 32'd7);
    queue_pop();
    queue_pop();
    while (gen_cnt < sps_pkg::Capacity) queue_push($urandom, pick_prio(1'b1));
    queue_push($urandom, '1);
    queue_pop();
    queue_pop();

    while (pending_ops.size() < StimItems) begin
      mode = $urandom_range(0, 9);
      narrow = $urandom_range(0, 1);
      n = $urandom_range(0, 2);
      if (mode < 2) begin
        // fill up and sometimes overrun
        while (gen_cnt < sps_pkg::Capacity) queue_push($urandom, pick_prio(narrow));
        repeat (n) queue_push($urandom, pick_prio(narrow));
      end else if (mode < 4) begin
        // drain and sometimes underrun
        while (gen_cnt > 0) queue_pop();
        repeat (n) queue_pop();
      end else begin
        repeat ($urandom_range(10, 40)) begin
          if ($urandom_range(0, 99) < 55) queue_push($urandom, pick_prio(narrow));
          else queue_pop();
        end
      end
    end
    total_items = pending_ops.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (done_cnt < total_items)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_tops.size() != 0)
      report_mismatch("results still missing", expected_tops.size(), '0);

    if (fail_cnt == 0) begin
      $display("PASS sorted_priority_stack");
    end else begin
      $display("FAIL sorted_priority_stack");
    end
    $finish;
  end

endmodule
